// ===== rtl/phmr_pkg.sv =====
// Package with the beat types, configuration types and protocol constants of the header unit.
`default_nettype none

package phmr_pkg;

    localparam logic [7:0]  PROTO_TCP     = 8'h06;
    localparam logic [7:0]  PROTO_UDP     = 8'h11;
    localparam logic [15:0] IP_FIRST_WORD = 16'h4500;
    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

    localparam int CFG_NUM_REGS  = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MAC1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MAC2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_IP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REWR_MAC1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REWR_MAC2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REWR_IP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_PAIRS  = 3'd7;

    // Field positions inside the enable masks: first MAC, second MAC,
    // source IP, destination IP, source port, destination port.
    localparam int FLD_MAC1  = 0;
    localparam int FLD_MAC2  = 1;
    localparam int FLD_SIP   = 2;
    localparam int FLD_DIP   = 3;
    localparam int FLD_SPORT = 4;
    localparam int FLD_DPORT = 5;
    localparam int FLD_NUM   = 6;

    typedef struct packed {
        logic [47:0] mac_first;
        logic [47:0] mac_second;
        logic [15:0] ip_total_length;
        logic [15:0] ip_ident;
        logic [15:0] ip_flags_fragment;
        logic [7:0]  ip_ttl;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } hdr_t;

    typedef struct packed {
        logic        accept;
        logic [47:0] out_mac_first;
        logic [47:0] out_mac_second;
        logic [31:0] out_src_ip;
        logic [31:0] out_dst_ip;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [15:0] ip_checksum;
        logic [15:0] udp_checksum;
        logic        udp_checksum_valid;
    } res_t;

    typedef struct packed {
        logic               udp_mode;
        logic [FLD_NUM-1:0] match_en;
        logic [FLD_NUM-1:0] rewrite_en;
        logic [47:0]        match_mac1;
        logic [47:0]        match_mac2;
        logic [31:0]        match_sip;
        logic [31:0]        match_dip;
        logic [15:0]        match_sport;
        logic [15:0]        match_dport;
        logic [47:0]        rewr_mac1;
        logic [47:0]        rewr_mac2;
        logic [31:0]        rewr_sip;
        logic [31:0]        rewr_dip;
        logic [15:0]        rewr_sport;
        logic [15:0]        rewr_dport;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/phmr_cfg_regs.sv =====
// Configuration register file of the header unit.
`default_nettype none

module phmr_cfg_regs
    import phmr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [12:0] mode_reg;
    logic [47:0] match_mac1_reg;
    logic [47:0] match_mac2_reg;
    logic [63:0] match_ip_reg;
    logic [47:0] rewr_mac1_reg;
    logic [47:0] rewr_mac2_reg;
    logic [63:0] rewr_ip_reg;
    logic [63:0] ports_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            match_mac1_reg <= '0;
            match_mac2_reg <= '0;
            match_ip_reg   <= '0;
            rewr_mac1_reg  <= '0;
            rewr_mac2_reg  <= '0;
            rewr_ip_reg    <= '0;
            ports_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[12:0];
                CFG_MATCH_MAC1: match_mac1_reg <= cfg_data[47:0];
                CFG_MATCH_MAC2: match_mac2_reg <= cfg_data[47:0];
                CFG_MATCH_IP:   match_ip_reg   <= cfg_data;
                CFG_REWR_MAC1:  rewr_mac1_reg  <= cfg_data[47:0];
                CFG_REWR_MAC2:  rewr_mac2_reg  <= cfg_data[47:0];
                CFG_REWR_IP:    rewr_ip_reg    <= cfg_data;
                CFG_PORT_PAIRS: ports_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.udp_mode    = mode_reg[0];
        cfg.match_en    = mode_reg[6:1];
        cfg.rewrite_en  = mode_reg[12:7];
        cfg.match_mac1  = match_mac1_reg;
        cfg.match_mac2  = match_mac2_reg;
        cfg.match_sip   = match_ip_reg[63:32];
        cfg.match_dip   = match_ip_reg[31:0];
        cfg.match_sport = ports_reg[63:48];
        cfg.match_dport = ports_reg[47:32];
        cfg.rewr_mac1   = rewr_mac1_reg;
        cfg.rewr_mac2   = rewr_mac2_reg;
        cfg.rewr_sip    = rewr_ip_reg[63:32];
        cfg.rewr_dip    = rewr_ip_reg[31:0];
        cfg.rewr_sport  = ports_reg[31:16];
        cfg.rewr_dport  = ports_reg[15:0];
    end

endmodule

`default_nettype wire

// ===== rtl/phmr_rewrite.sv =====
// Match compare and field rewrite logic of the header unit.
`default_nettype none

module phmr_rewrite
    import phmr_pkg::*;
(
    input  wire cfg_t  cfg,
    input  wire hdr_t  hdr,
    output logic       ok,
    output hdr_t       hdr_out
);

    logic [FLD_NUM-1:0] equal;
    logic [7:0]         want_proto;
    logic [FLD_NUM-1:0] apply;

    always_comb
    begin
        want_proto       = cfg.udp_mode ? PROTO_UDP : PROTO_TCP;
        equal[FLD_MAC1]  = hdr.mac_first  == cfg.match_mac1;
        equal[FLD_MAC2]  = hdr.mac_second == cfg.match_mac2;
        equal[FLD_SIP]   = hdr.src_ip     == cfg.match_sip;
        equal[FLD_DIP]   = hdr.dst_ip     == cfg.match_dip;
        equal[FLD_SPORT] = hdr.src_port   == cfg.match_sport;
        equal[FLD_DPORT] = hdr.dst_port   == cfg.match_dport;

        // A field that is not enabled for matching always passes.
        ok    = (hdr.ip_protocol == want_proto) && (&(equal | ~cfg.match_en));
        apply = ok ? cfg.rewrite_en : '0;

        hdr_out            = hdr;
        if (apply[FLD_MAC1])
        begin
            hdr_out.mac_first = cfg.rewr_mac1;
        end
        if (apply[FLD_MAC2])
        begin
            hdr_out.mac_second = cfg.rewr_mac2;
        end
        if (apply[FLD_SIP])
        begin
            hdr_out.src_ip = cfg.rewr_sip;
        end
        if (apply[FLD_DIP])
        begin
            hdr_out.dst_ip = cfg.rewr_dip;
        end
        if (apply[FLD_SPORT])
        begin
            hdr_out.src_port = cfg.rewr_sport;
        end
        if (apply[FLD_DPORT])
        begin
            hdr_out.dst_port = cfg.rewr_dport;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/phmr_csum.sv =====
// Ones-complement checksum logic for the IPv4 header and the UDP header.
`default_nettype none

module phmr_csum
    import phmr_pkg::*;
(
    input  wire logic  ok,
    input  wire logic  udp_mode,
    input  wire hdr_t  hdr,
    output logic [15:0] ip_checksum,
    output logic [15:0] udp_checksum,
    output logic        udp_checksum_valid
);

    // At most nine 16-bit words are summed, so 20 bits hold the total
    // and two end-around folds bring it back to 16 bits.
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

    logic [19:0] addr_sum;
    logic [19:0] ip_sum;
    logic [19:0] udp_sum;
    logic [15:0] udp_raw;

    always_comb
    begin
        addr_sum = {4'd0, hdr.src_ip[31:16]} + {4'd0, hdr.src_ip[15:0]}
                 + {4'd0, hdr.dst_ip[31:16]} + {4'd0, hdr.dst_ip[15:0]};
        ip_sum   = addr_sum + {4'd0, IP_FIRST_WORD} + {4'd0, hdr.ip_total_length}
                 + {4'd0, hdr.ip_ident} + {4'd0, hdr.ip_flags_fragment}
                 + {4'd0, hdr.ip_ttl, hdr.ip_protocol};
        // Pseudo-header protocol and length, the two ports and the UDP length.
        udp_sum  = addr_sum + {12'd0, PROTO_UDP} + {4'd0, UDP_HDR_LEN}
                 + {4'd0, hdr.src_port} + {4'd0, hdr.dst_port} + {4'd0, UDP_HDR_LEN};
        udp_raw  = ~fold16(udp_sum);

        ip_checksum        = ok ? ~fold16(ip_sum) : '0;
        udp_checksum_valid = ok && udp_mode;
        if (!udp_checksum_valid)
        begin
            udp_checksum = '0;
        end
        else if (udp_raw == '0)
        begin
            // A computed zero is sent as all ones.
            udp_checksum = 16'hFFFF;
        end
        else
        begin
            udp_checksum = udp_raw;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/packet_header_match_rewrite_unit.sv =====
// Top level of the Ethernet/IPv4 header match, rewrite and checksum unit.
//
// Usage:
// The unit takes one header beat on hdr at every rising edge where start is
// high and busy is low. busy is held low: a new header may be offered in
// every cycle, so the unit runs at one header per clock.
// Each header yields exactly one result beat on res, marked by done, which
// is high for a single cycle. The receiver has no way to stall it and must
// take the beat in that cycle.
// Pipeline: a header accepted at a rising edge is captured in the input register;
// the match, rewrite and both checksums are computed from that register and
// land in the result register, where done marks them. The depth is set by the
// two register ranks around the single combinational pass.
// Configuration: cfg_write, cfg_index and cfg_data write one of eight
// registers; indexes follow the register list in the package.
// Registers must only be written while no header is in flight.
// Reset: rst_n clears all configuration registers to zero and drops the
// beat valid flags, so no done strobe appears until a new header arrives.
`default_nettype none

module packet_header_match_rewrite_unit
    import phmr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire hdr_t                  hdr,
    output logic                       done,
    output res_t                       res,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    hdr_t  hdr_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    res_t  res_reg;
    res_t  res_next;
    logic  ok;
    hdr_t  hdr_rw;
    logic [15:0] ip_ck;
    logic [15:0] udp_ck;
    logic        udp_ck_valid;

    phmr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The pipeline never stalls, so the unit is always ready.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hdr_reg <= hdr;
        end
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    phmr_rewrite u_rewrite (
        .cfg     (cfg),
        .hdr     (hdr_reg),
        .ok      (ok),
        .hdr_out (hdr_rw)
    );

    phmr_csum u_csum (
        .ok                 (ok),
        .udp_mode           (cfg.udp_mode),
        .hdr                (hdr_rw),
        .ip_checksum        (ip_ck),
        .udp_checksum       (udp_ck),
        .udp_checksum_valid (udp_ck_valid)
    );

    always_comb
    begin
        res_next.accept             = ok;
        res_next.out_mac_first      = hdr_rw.mac_first;
        res_next.out_mac_second     = hdr_rw.mac_second;
        res_next.out_src_ip         = hdr_rw.src_ip;
        res_next.out_dst_ip         = hdr_rw.dst_ip;
        res_next.out_src_port       = hdr_rw.src_port;
        res_next.out_dst_port       = hdr_rw.dst_port;
        res_next.ip_checksum        = ip_ck;
        res_next.udp_checksum       = udp_ck;
        res_next.udp_checksum_valid = udp_ck_valid;
    end

    assign done = out_valid_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the header match, rewrite and checksum unit.
`timescale 1ns / 1ps

module tb_top
    import phmr_pkg::*;
();

    // Bit positions inside the mode register: UDP select, then the six match
    // enables, then the six rewrite enables, each in package field order.
    localparam int MATCH_BASE   = 1;
    localparam int REWRITE_BASE = 7;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BEATS    = 100;

    // Register settings used by the directed part of the run.
    typedef enum int {
        PLAN_KEEP,
        PLAN_UDP_OPEN,
        PLAN_UDP_ALL_ONES,
        PLAN_TCP_ZERO_MATCH,
        PLAN_PORT_SELECT
    } plan_e;

    typedef struct {
        plan_e plan;
        hdr_t  h;
        bit    typed;
        res_t  want;
    } step_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    hdr_t hdr;
    logic done;
    res_t res;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register image as the unit should hold it, updated from the write port.
    logic [63:0] cfg_copy [CFG_NUM_REGS];
    // Values that the stimulus is about to load into the registers.
    logic [63:0] cfg_plan [CFG_NUM_REGS];

    res_t  pending_results[$];
    step_t script[$];

    // A directed row may carry a hand-typed result; it travels with the beat.
    bit   row_typed;
    res_t row_want;

    int mismatches;
    int result_index;
    int quiet_cycles;

    packet_header_match_rewrite_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .hdr       (hdr),
        .done      (done),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One's-complement sum: fold every carry back in until 16 bits remain.
    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        logic [31:0] t;
        t = s;
        while (t > 32'hFFFF)
            t = (t & 32'hFFFF) + (t >> 16);
        return t[15:0];
    endfunction

    // Match, rewrite and checksums of one header under the current registers.
    function automatic res_t predict_header(input hdr_t h);
        logic [12:0] mode;
        logic [5:0]  m_en;
        logic [5:0]  r_en;
        logic        udp;
        logic        pass;
        logic [31:0] ip_words;
        logic [31:0] s;
        res_t        r;
        mode = cfg_copy[CFG_MODE][12:0];
        udp  = mode[0];
        m_en = mode[MATCH_BASE +: FLD_NUM];
        r_en = mode[REWRITE_BASE +: FLD_NUM];

        pass = (h.ip_protocol == (udp ? PROTO_UDP : PROTO_TCP));
        if (m_en[FLD_MAC1] && h.mac_first != cfg_copy[CFG_MATCH_MAC1][47:0])
            pass = 1'b0;
        if (m_en[FLD_MAC2] && h.mac_second != cfg_copy[CFG_MATCH_MAC2][47:0])
            pass = 1'b0;
        if (m_en[FLD_SIP] && h.src_ip != cfg_copy[CFG_MATCH_IP][63:32])
            pass = 1'b0;
        if (m_en[FLD_DIP] && h.dst_ip != cfg_copy[CFG_MATCH_IP][31:0])
            pass = 1'b0;
        if (m_en[FLD_SPORT] && h.src_port != cfg_copy[CFG_PORT_PAIRS][63:48])
            pass = 1'b0;
        if (m_en[FLD_DPORT] && h.dst_port != cfg_copy[CFG_PORT_PAIRS][47:32])
            pass = 1'b0;

        r = '0;
        r.accept         = pass;
        r.out_mac_first  = h.mac_first;
        r.out_mac_second = h.mac_second;
        r.out_src_ip     = h.src_ip;
        r.out_dst_ip     = h.dst_ip;
        r.out_src_port   = h.src_port;
        r.out_dst_port   = h.dst_port;

        if (pass)
        begin
            if (r_en[FLD_MAC1])  r.out_mac_first  = cfg_copy[CFG_REWR_MAC1][47:0];
            if (r_en[FLD_MAC2])  r.out_mac_second = cfg_copy[CFG_REWR_MAC2][47:0];
            if (r_en[FLD_SIP])   r.out_src_ip     = cfg_copy[CFG_REWR_IP][63:32];
            if (r_en[FLD_DIP])   r.out_dst_ip     = cfg_copy[CFG_REWR_IP][31:0];
            if (r_en[FLD_SPORT]) r.out_src_port   = cfg_copy[CFG_PORT_PAIRS][31:16];
            if (r_en[FLD_DPORT]) r.out_dst_port   = cfg_copy[CFG_PORT_PAIRS][15:0];

            ip_words = r.out_src_ip[31:16] + r.out_src_ip[15:0]
                     + r.out_dst_ip[31:16] + r.out_dst_ip[15:0];
            s = IP_FIRST_WORD + h.ip_total_length + h.ip_ident + h.ip_flags_fragment
              + {h.ip_ttl, h.ip_protocol} + ip_words;
            r.ip_checksum = ~fold_sum(s);

            // The UDP sum covers the pseudo-header and the 8-byte UDP header
            // only, with the length counted in both places.
            if (udp)
            begin
                s = ip_words + PROTO_UDP + UDP_HDR_LEN + r.out_src_port
                  + r.out_dst_port + UDP_HDR_LEN;
                r.udp_checksum = ~fold_sum(s);
                if (r.udp_checksum == 16'h0000)
                    r.udp_checksum = 16'hFFFF;
                r.udp_checksum_valid = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed headers: right protocol and match values copied from
    // the registers, with an occasional field disturbed. The rest is noise.
    function automatic hdr_t random_header();
        hdr_t h;
        logic udp;
        int   kind;
        udp  = cfg_copy[CFG_MODE][0];
        kind = $urandom_range(0, 99);
        // The header is exactly four 64-bit chunks wide.
        h = {pick_value(), pick_value(), pick_value(), pick_value()};
        if (kind < 75)
        begin
            h.ip_protocol = udp ? PROTO_UDP : PROTO_TCP;
            if ($urandom_range(0, 9) != 0) h.mac_first  = cfg_copy[CFG_MATCH_MAC1][47:0];
            if ($urandom_range(0, 9) != 0) h.mac_second = cfg_copy[CFG_MATCH_MAC2][47:0];
            if ($urandom_range(0, 9) != 0) h.src_ip     = cfg_copy[CFG_MATCH_IP][63:32];
            if ($urandom_range(0, 9) != 0) h.dst_ip     = cfg_copy[CFG_MATCH_IP][31:0];
            if ($urandom_range(0, 9) != 0) h.src_port   = cfg_copy[CFG_PORT_PAIRS][63:48];
            if ($urandom_range(0, 9) != 0) h.dst_port   = cfg_copy[CFG_PORT_PAIRS][47:32];
        end
        else if (kind < 85)
            h.ip_protocol = PROTO_TCP;
        else if (kind < 95)
            h.ip_protocol = PROTO_UDP;
        return h;
    endfunction

    function automatic hdr_t build_header(
        input logic [47:0] mac1, input logic [47:0] mac2,
        input logic [15:0] tlen, input logic [15:0] ident, input logic [15:0] frag,
        input logic [7:0] ttl, input logic [7:0] proto,
        input logic [31:0] sip, input logic [31:0] dip,
        input logic [15:0] sport, input logic [15:0] dport);
        return {mac1, mac2, tlen, ident, frag, ttl, proto, sip, dip, sport, dport};
    endfunction

    task automatic add_step(input plan_e p, input hdr_t h, input bit typed, input res_t want);
        step_t s;
        s.plan  = p;
        s.h     = h;
        s.typed = typed;
        s.want  = want;
        script.insert(script.size(), s);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat %0d: %s expected %h, got %h",
                         result_index, name, want, got);
        end
    endtask

    task automatic check_result(input res_t want, input res_t got);
        check_field("accept",             want.accept,             got.accept);
        check_field("out_mac_first",      want.out_mac_first,      got.out_mac_first);
        check_field("out_mac_second",     want.out_mac_second,     got.out_mac_second);
        check_field("out_src_ip",         want.out_src_ip,         got.out_src_ip);
        check_field("out_dst_ip",         want.out_dst_ip,         got.out_dst_ip);
        check_field("out_src_port",       want.out_src_port,       got.out_src_port);
        check_field("out_dst_port",       want.out_dst_port,       got.out_dst_port);
        check_field("ip_checksum",        want.ip_checksum,        got.ip_checksum);
        check_field("udp_checksum",       want.udp_checksum,       got.udp_checksum);
        check_field("udp_checksum_valid", want.udp_checksum_valid, got.udp_checksum_valid);
    endtask

    // Everything here samples values from before the edge: the unit and the
    // stimulus both update with nonblocking assignments.
    always @(posedge clk)
    begin : monitor
        res_t want;
        logic took;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODE:
                        cfg_copy[cfg_index] <= {51'd0, cfg_data[12:0]};
                    CFG_MATCH_MAC1, CFG_MATCH_MAC2, CFG_REWR_MAC1, CFG_REWR_MAC2:
                        cfg_copy[cfg_index] <= {16'd0, cfg_data[47:0]};
                    default:
                        cfg_copy[cfg_index] <= cfg_data;
                endcase
            end

            took = start && !busy;
            if (took)
                pending_results.insert(pending_results.size(),
                                       row_typed ? row_want : predict_header(hdr));

            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with nothing expected",
                                 result_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_result(want, res);
                end
                result_index++;
            end

            quiet_cycles <= (took || done || cfg_write) ? 0 : quiet_cycles + 1;
        end
    end

    // Offer one header beat and hold it until the unit takes it.
    task automatic send_header(input hdr_t h);
        hdr   <= h;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    // Stop offering beats and let every expected result come back before
    // the registers are touched.
    task automatic quiesce();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_plan();
        for (int i = 0; i < CFG_NUM_REGS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= cfg_plan[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic choose_plan(input plan_e p);
        for (int i = 0; i < CFG_NUM_REGS; i++)
            cfg_plan[i] = '0;
        case (p)
            PLAN_UDP_OPEN:
                cfg_plan[CFG_MODE] = 64'h1;
            PLAN_UDP_ALL_ONES:
            begin
                // Upper bits beyond each register's width are set on purpose.
                cfg_plan[CFG_MODE]       = '1;
                cfg_plan[CFG_MATCH_MAC1] = '1;
                cfg_plan[CFG_MATCH_MAC2] = '1;
                cfg_plan[CFG_MATCH_IP]   = '1;
                cfg_plan[CFG_REWR_MAC1]  = 64'hA5A5_0123_4567_89AB;
                cfg_plan[CFG_REWR_MAC2]  = 64'hDEAD_0000_0000_0001;
                cfg_plan[CFG_REWR_IP]    = 64'h0A00_0001_C0A8_0001;
                cfg_plan[CFG_PORT_PAIRS] = 64'hFFFF_FFFF_1234_0035;
            end
            PLAN_TCP_ZERO_MATCH:
            begin
                cfg_plan[CFG_MODE]       = ~64'h1;
                cfg_plan[CFG_REWR_MAC1]  = '1;
                cfg_plan[CFG_REWR_MAC2]  = '1;
                cfg_plan[CFG_REWR_IP]    = '1;
                cfg_plan[CFG_PORT_PAIRS] = 64'h0000_0000_FFFF_FFFF;
            end
            PLAN_PORT_SELECT:
            begin
                cfg_plan[CFG_MODE] = (64'h1 << (MATCH_BASE + FLD_SPORT))
                                   | (64'h1 << (MATCH_BASE + FLD_DPORT))
                                   | (64'h1 << (REWRITE_BASE + FLD_SIP))
                                   | (64'h1 << (REWRITE_BASE + FLD_DPORT));
                cfg_plan[CFG_MATCH_MAC1] = 64'h0000_0200_0000_0001;
                cfg_plan[CFG_MATCH_IP]   = 64'h0A0A_0A0A_0B0B_0B0B;
                cfg_plan[CFG_REWR_MAC2]  = 64'h0000_0200_0000_0002;
                cfg_plan[CFG_REWR_IP]    = 64'hC0A8_0A0A_0000_0000;
                cfg_plan[CFG_PORT_PAIRS] = 64'h0050_01BB_0000_1F90;
            end
            default:
                ;
        endcase
    endtask

    task automatic fill_script();
        hdr_t zero_tcp;
        hdr_t zero_udp;
        hdr_t ones;
        zero_tcp = build_header(0, 0, 0, 0, 0, 0, PROTO_TCP, 0, 0, 0, 0);
        zero_udp = build_header(0, 0, 0, 0, 0, 0, PROTO_UDP, 0, 0, 0, 0);
        ones     = '1;

        // Reset registers: TCP selected, nothing enabled.
        add_step(PLAN_KEEP, '0, 1'b1, '0);
        add_step(PLAN_KEEP, ones, 1'b1,
                 {1'b0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0});
        add_step(PLAN_KEEP,
                 build_header(48'h0011_2233_4455, 48'h6677_8899_AABB, 16'd60, 16'h1C46,
                              16'h4000, 8'd64, PROTO_UDP, 32'hC0A8_0001, 32'hC0A8_00C7,
                              16'd5353, 16'd53), 1'b1,
                 {1'b0, 48'h0011_2233_4455, 48'h6677_8899_AABB, 32'hC0A8_0001,
                  32'hC0A8_00C7, 16'd5353, 16'd53, 16'h0000, 16'h0000, 1'b0});
        add_step(PLAN_KEEP, zero_tcp, 1'b1,
                 {1'b1, 48'h0, 48'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hBAF9, 16'h0, 1'b0});
        add_step(PLAN_KEEP,
                 build_header('1, '1, '1, '1, '1, '1, PROTO_TCP, '1, '1, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP,
                 build_header(48'h0200_0000_00AA, 48'h0200_0000_00BB, 16'd1500, 16'hBEEF,
                              16'h4000, 8'd128, PROTO_TCP, 32'h0A00_0002, 32'h0A00_0003,
                              16'd443, 16'd50123), 1'b0, '0);

        // UDP selected, no match or rewrite.
        add_step(PLAN_UDP_OPEN, zero_udp, 1'b0, '0);
        add_step(PLAN_KEEP, zero_tcp, 1'b1, '0);
        // The UDP sum lands on zero and must go out as all ones.
        add_step(PLAN_KEEP, build_header(0, 0, 0, 0, 0, 0, PROTO_UDP, 0, 0, 16'hFFDE, 0),
                 1'b1,
                 {1'b1, 48'h0, 48'h0, 32'h0, 32'h0, 16'hFFDE, 16'h0, 16'hBAEE, 16'hFFFF,
                  1'b1});
        add_step(PLAN_KEEP,
                 build_header('1, '1, '1, '1, '1, '1, PROTO_UDP, '1, '1, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP,
                 build_header(48'h0001_0203_0405, 48'h0A0B_0C0D_0E0F, 16'd28, 16'h0001,
                              16'h0000, 8'd1, PROTO_UDP, 32'hFFFF_0000, 32'h0000_FFFF,
                              16'd68, 16'd67), 1'b0, '0);

        // Every match and rewrite on, match values all ones; then each field
        // alone breaks the match.
        add_step(PLAN_UDP_ALL_ONES,
                 build_header('1, '1, 16'd36, 16'h1234, 16'h0, 8'd17, PROTO_UDP, '1, '1,
                              '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header(48'hFFFF_FFFF_FFFE, '1, 0, 0, 0, 0, PROTO_UDP,
                                         '1, '1, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header('1, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, PROTO_UDP,
                                         '1, '1, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header('1, '1, 0, 0, 0, 0, PROTO_UDP,
                                         32'hFFFF_FFEF, '1, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header('1, '1, 0, 0, 0, 0, PROTO_UDP,
                                         '1, 32'h0, '1, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header('1, '1, 0, 0, 0, 0, PROTO_UDP,
                                         '1, '1, 16'hFF7F, '1), 1'b0, '0);
        add_step(PLAN_KEEP, build_header('1, '1, 0, 0, 0, 0, PROTO_UDP,
                                         '1, '1, '1, 16'h0000), 1'b0, '0);

        // TCP with every match on against zero values, rewrites to all ones.
        add_step(PLAN_TCP_ZERO_MATCH, zero_tcp, 1'b0, '0);
        add_step(PLAN_KEEP, zero_udp, 1'b0, '0);

        // Only the ports are matched; source IP and destination port rewritten.
        add_step(PLAN_PORT_SELECT,
                 build_header(48'h0200_0000_0001, 48'h0200_0000_0002, 16'd40, 16'h0042,
                              16'h4000, 8'd63, PROTO_TCP, 32'h0A0A_0A0A, 32'h0B0B_0B0B,
                              16'h0050, 16'h01BB), 1'b0, '0);
        add_step(PLAN_KEEP,
                 build_header(48'h0200_0000_0001, 48'h0200_0000_0002, 16'd40, 16'h0043,
                              16'h4000, 8'd63, PROTO_TCP, 32'h0A0A_0A0A, 32'h0B0B_0B0B,
                              16'h0050, 16'h01BC), 1'b0, '0);
        add_step(PLAN_KEEP,
                 build_header(48'h8000_0000_0000, 48'h0000_0000_0001, 16'hFFFF, 16'h0,
                              16'hFFFF, 8'hFF, PROTO_TCP, 32'h8000_0000, 32'h0000_0001,
                              16'h0050, 16'h01BB), 1'b0, '0);
    endtask

    // Stimulus: directed table first, then random phases with fresh registers.
    initial
    begin : stimulus
        bit idle_on;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        hdr       <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        row_typed <= 1'b0;
        row_want  <= '0;
        for (int i = 0; i < CFG_NUM_REGS; i++)
            cfg_copy[i] = '0;
        mismatches   = 0;
        result_index = 0;
        quiet_cycles = 0;

        fill_script();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < script.size(); n++)
        begin
            if (script[n].plan != PLAN_KEEP)
            begin
                quiesce();
                choose_plan(script[n].plan);
                load_plan();
            end
            row_typed <= script[n].typed;
            row_want  <= script[n].want;
            send_header(script[n].h);
        end

        row_typed <= 1'b0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiesce();
            for (int i = 0; i < CFG_NUM_REGS; i++)
                cfg_plan[i] = {$urandom, $urandom};
            // A few phases pin the registers to their extremes.
            if (phase == 1)
            begin
                for (int i = 0; i < CFG_NUM_REGS; i++)
                    cfg_plan[i] = '1;
            end
            else if (phase == 2)
            begin
                for (int i = 0; i < CFG_NUM_REGS; i++)
                    cfg_plan[i] = '0;
                cfg_plan[CFG_MODE] = {$urandom, $urandom};
            end
            else if (phase == 3)
                cfg_plan[CFG_MODE] = '0;
            load_plan();

            // The last phase runs back to back; others idle in random bursts,
            // with an occasional phase left without gaps.
            idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_header(random_header());
                if (idle_on && $urandom_range(0, 5) == 0)
                    idle_burst();
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("packet_header_match_rewrite_unit: match");
        else
            $display("packet_header_match_rewrite_unit: mismatch");
        $finish;
    end

    // Ends the run if neither beats, results nor register writes move for
    // too long.
    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("packet_header_match_rewrite_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phmr_pkg.sv
rtl/phmr_cfg_regs.sv
rtl/phmr_rewrite.sv
rtl/phmr_csum.sv
rtl/packet_header_match_rewrite_unit.sv
tb/tb_top.sv
